>>> sv/pss_pkg.sv
// Package with the shared types, codes and constants of the priority step scheduler.
package pss_pkg;

    // Default table depth and field widths.
    localparam int PSS_TASK_SLOTS = 8;
    localparam int VALUE_W        = 12;
    localparam int PRIO_W         = 8;
    localparam int DUR_W          = 16;
    localparam int STEPS_W        = 8;
    localparam int STATUS_W       = 3;
    localparam int TIME_W         = 16;
    localparam int PROG_W         = 24;
    localparam int SQ_W           = 2 * VALUE_W;
    localparam int PROD_W         = SQ_W + STEPS_W;

    // Divider geometry: one quotient bit per cycle.
    localparam int DIVIDEND_W = PROD_W;
    localparam int DIVISOR_W  = STEPS_W;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

    typedef enum logic [0:0] {
        REQ_ADD = 1'b0,
        REQ_RUN = 1'b1
    } t_req_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_STEPPED = 3'd2,
        ST_DONE    = 3'd3,
        ST_IDLE    = 3'd4
    } t_status;

    typedef struct packed {
        t_req_kind            req_type;
        logic [VALUE_W-1:0]   task_value;
        logic [PRIO_W-1:0]    task_priority;
        logic [DUR_W-1:0]     task_duration;
        logic [STEPS_W-1:0]   task_steps;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   served_value;
        logic [PRIO_W-1:0]    served_priority;
        logic [STEPS_W-1:0]   step_number;
        logic [STEPS_W-1:0]   step_total;
        logic [TIME_W-1:0]    step_time;
        logic [PROG_W-1:0]    progress_result;
    } t_rsp;

    // One table entry as it is kept in the slot memory.
    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [PRIO_W-1:0]    prio;
        logic [DUR_W-1:0]     duration;
        logic [STEPS_W-1:0]   total;
        logic [STEPS_W-1:0]   done;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_MUL1,
        S_MUL2,
        S_DIV_T,
        S_WAIT_T,
        S_DIV_P,
        S_WAIT_P,
        S_FIN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> sv/pss_stream_if.sv
// Valid/ready channel interface carrying one payload item per transfer.
interface pss_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/pss_div.sv
// Restoring divider that produces one quotient bit per cycle.
module pss_div import pss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    trial;
    logic                  take;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign take  = (trial >= {1'b0, r_dvs});

    // Control: the dividend register turns into the quotient as it shifts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= take ? DIVISOR_W'(trial - {1'b0, r_dvs}) : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], take};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> sv/priority_step_task_scheduler_core.sv
// Top level of the priority step scheduler: slot memory, control sequencer and result register.
//
// The block keeps an insertion-ordered table of up to TASK_SLOTS tasks in a single-port-write,
// single-port-read slot memory with a registered read. A run request scans every occupied slot
// through the memory read port, squares the value and scales it by the step count in two
// registered multiplies, and then divides the duration and the scaled product by the total
// step count in one shared bit-serial divider; a task whose total is zero skips the divider.
// A completed task is removed by moving each later slot down one entry. A run on an empty
// table and a dropped add go straight to the result register. One request is in flight at a
// time; the finished result sits in an output register so the next request can be taken while
// it waits for its transfer.
module priority_step_task_scheduler_core import pss_pkg::*; #(
    parameter int TASK_SLOTS = PSS_TASK_SLOTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pss_stream_if.sink   i_req,
    pss_stream_if.source o_rsp
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    t_state             r_state;
    t_state             n_state;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_issue;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic [IDX_W-1:0]   r_best_idx;
    t_slot              r_best;
    logic [STEPS_W-1:0] r_done;
    logic               r_fin;
    logic [SQ_W-1:0]    r_sq;
    logic [PROD_W-1:0]  r_prod;
    logic [TIME_W-1:0]  r_time;
    logic [PROG_W-1:0]  r_prog;
    logic [CNT_W-1:0]   r_sh;
    t_rsp               r_res;
    t_rsp               r_out;
    logic               r_out_valid;

    t_slot              r_mem [TASK_SLOTS];
    t_slot              r_rd_data;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_slot              mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic               in_xfer;
    logic               out_free;
    logic               table_full;
    logic               scan_end;
    logic               more_shift;
    logic [STEPS_W-1:0] done_inc;
    t_status            idle_status;
    t_req               req;

    assign req         = i_req.payload;
    assign in_xfer     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign table_full  = (r_count == CNT_W'(TASK_SLOTS));
    assign scan_end    = (r_issue == r_count) && !r_pend;
    assign more_shift  = ((CNT_W + 1)'(r_sh) + 1'b1) < (CNT_W + 1)'(r_count);
    assign done_inc    = (r_best.done == STEPS_MAX) ? r_best.done : r_best.done + 1'b1;
    assign idle_status = (req.req_type == REQ_ADD) ? (table_full ? ST_FULL : ST_ADDED)
                                                   : ST_IDLE;

    // Slot memory: one write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[mem_raddr];
    end

    pss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (req.req_type == REQ_RUN && r_count != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = (r_best.total == '0) ? S_FIN : S_DIV_T;
            S_DIV_T: n_state = S_WAIT_T;
            S_WAIT_T: begin
                if (div_rsp.done) begin
                    n_state = S_DIV_P;
                end
            end
            S_DIV_P: n_state = S_WAIT_P;
            S_WAIT_P: begin
                if (div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = (r_fin && more_shift) ? S_SHIFT_RD : S_OUT;
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_FIN;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory, divider and handshake controls.
    always_comb begin
        i_req.ready      = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = r_rd_data;
        mem_raddr        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = r_best.total;
        case (r_state)
            S_IDLE: begin
                i_req.ready        = 1'b1;
                mem_waddr          = r_count[IDX_W-1:0];
                mem_wdata.value    = req.task_value;
                mem_wdata.prio     = req.task_priority;
                mem_wdata.duration = req.task_duration;
                mem_wdata.total    = req.task_steps;
                mem_wdata.done     = '0;
                mem_we = i_req.valid && (req.req_type == REQ_ADD) && !table_full;
            end
            S_SCAN: begin
                mem_raddr = r_issue[IDX_W-1:0];
            end
            S_MUL1: begin
                // Write the advanced step count back unless the task leaves the table.
                mem_waddr      = r_best_idx;
                mem_wdata      = r_best;
                mem_wdata.done = done_inc;
                mem_we         = (done_inc < r_best.total);
            end
            S_DIV_T: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(r_best.duration);
            end
            S_DIV_P: begin
                div_req.start = 1'b1;
            end
            S_SHIFT_RD: begin
                mem_raddr = IDX_W'(r_sh + 1'b1);
            end
            S_SHIFT_WR: begin
                mem_waddr = r_sh[IDX_W-1:0];
                mem_we    = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && in_xfer && req.req_type == REQ_ADD && !table_full) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_FIN && n_state == S_OUT && r_fin) begin
                r_count <= r_count - 1'b1;
            end
            if (r_state == S_SCAN) begin
                r_pend <= (r_issue != r_count);
            end else begin
                r_pend <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_issue <= '0;
                r_res   <= '{status: idle_status, default: '0};
            end
            S_SCAN: begin
                // Pipelined scan: issue the next read while comparing the previous one.
                if (r_issue != r_count) begin
                    r_issue    <= r_issue + 1'b1;
                    r_pend_idx <= r_issue[IDX_W-1:0];
                end
                if (r_pend && (r_pend_idx == '0 || r_rd_data.prio > r_best.prio)) begin
                    r_best     <= r_rd_data;
                    r_best_idx <= r_pend_idx;
                end
            end
            S_MUL1: begin
                r_sq   <= SQ_W'(r_best.value) * SQ_W'(r_best.value);
                r_done <= done_inc;
                r_fin  <= (done_inc >= r_best.total);
                r_sh   <= CNT_W'(r_best_idx);
            end
            S_MUL2: begin
                r_prod <= PROD_W'(r_sq) * PROD_W'(r_done);
                r_time <= '0;
                r_prog <= '0;
            end
            S_WAIT_T: begin
                if (div_rsp.done) begin
                    r_time <= div_rsp.quotient[TIME_W-1:0];
                end
            end
            S_WAIT_P: begin
                if (div_rsp.done) begin
                    r_prog <= div_rsp.quotient[PROG_W-1:0];
                end
            end
            S_FIN: begin
                r_res.status          <= r_fin ? ST_DONE : ST_STEPPED;
                r_res.served_value    <= r_best.value;
                r_res.served_priority <= r_best.prio;
                r_res.step_number     <= r_done;
                r_res.step_total      <= r_best.total;
                r_res.step_time       <= r_time;
                r_res.progress_result <= r_prog;
            end
            S_SHIFT_WR: begin
                r_sh <= r_sh + 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_sh <= r_sh;
            end
        endcase
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // The occupancy never goes past the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TASK_SLOTS))
        else $error("slot count exceeds table depth");

    // An add that finds room grows the table by exactly one entry.
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && req.req_type == REQ_ADD && !table_full)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted add did not grow the table");

    // The slot memory is not written while the priority scan reads it.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !mem_we)
        else $error("slot write during scan");

    // The divider is started only when idle and never with a zero divisor.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (!div_rsp.busy && div_req.divisor != '0))
        else $error("bad divider start");

    // A full report is only given for a full table.
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_res.status == ST_FULL) |-> table_full)
        else $error("full reported with room left");

endmodule
